@@ rtl/rsa_pkg.sv @@
// Shared constants and types for the rank-sum AUC block.
package rsa_pkg;

    localparam int MAX_ITEMS   = 1024;
    localparam int ADDR_W      = $clog2(MAX_ITEMS);
    localparam int CNT_W       = $clog2(MAX_ITEMS + 1);
    localparam int SCORE_W     = 32;
    localparam int AUC_W       = 17;
    localparam int OUT_TDATA_W = ((AUC_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 2;
    // 2U <= 2 * npos * nneg, and the divisor is that same bound
    localparam int PROD_W      = 2 * CNT_W;
    localparam int U_W         = PROD_W + 1;
    localparam int REM_W       = U_W + 1;
    localparam int DIV_STEPS   = AUC_W;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    typedef enum logic [7:0] {
        ST_LOAD     = 8'b0000_0001,
        ST_FETCH    = 8'b0000_0010,
        ST_HOLD     = 8'b0000_0100,
        ST_SCAN     = 8'b0000_1000,
        ST_MULT     = 8'b0001_0000,
        ST_DIV_GO   = 8'b0010_0000,
        ST_DIV_WAIT = 8'b0100_0000,
        ST_DONE     = 8'b1000_0000
    } rsa_state_t;

endpackage

@@ rtl/rank_sum_auc.sv @@
// Top level: item store, pairwise rank-sum sequencer and AUC output register.
// Load: one word per cycle while s_tready is high; s_tready drops after the last word.
// Compute: after the last word, a pair scan over the single store read port, then a
//   17-step divider; a set with no positives or no negatives skips both.
// The result sits in an output register; loading of the next set overlaps its wait.
// Reset (aresetn low, synchronous) empties the set and clears the overflow flag.
module rank_sum_auc (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rsa_pkg::SCORE_W-1:0]       s_tdata,   // [31:0] score
    input  logic                              s_tuser,   // [0] is_positive
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rsa_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [16:0] auc, rest zero
    output logic [rsa_pkg::OUT_TUSER_W-1:0]   m_tuser    // [0] degenerate, [1] overflowed
);
    import rsa_pkg::*;

    // label in the top bit, score below
    logic [SCORE_W:0]    mem [MAX_ITEMS];
    logic [SCORE_W:0]    rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;

    rsa_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg,   cnt_next;
    logic [CNT_W-1:0]    npos_reg,  npos_next;
    logic [CNT_W-1:0]    nneg_reg,  nneg_next;
    logic                ovf_reg,   ovf_next;
    logic                degen_reg, degen_next;
    logic [CNT_W-1:0]    i_reg,     i_next;
    logic [CNT_W-1:0]    j_reg,     j_next;
    logic                vld_reg,   vld_next;
    logic [SCORE_W-1:0]  pkey_reg,  pkey_next;
    logic [U_W-1:0]      twu_reg,   twu_next;
    logic [PROD_W-1:0]   prod_reg,  prod_next;

    logic                m_valid_reg, m_valid_next;
    logic [AUC_W-1:0]    auc_reg,     auc_next;
    logic                odeg_reg,    odeg_next;
    logic                oovf_reg,    oovf_next;

    logic                accept;
    logic                room;
    logic                rd_label;
    logic [SCORE_W-1:0]  rd_score;
    logic                gt, eq;
    logic [CNT_W-1:0]    i_inc;
    logic                div_start;
    logic                div_done;
    logic [AUC_W-1:0]    div_quo;

    assign s_tready = (state_reg == ST_LOAD);
    assign accept   = s_tvalid && s_tready;
    assign room     = cnt_reg < CNT_W'(MAX_ITEMS);
    assign wr_en    = accept && room;
    assign rd_label = rd_data_reg[SCORE_W];
    assign rd_score = rd_data_reg[SCORE_W-1:0];
    assign gt       = $signed(pkey_reg) > $signed(rd_score);
    assign eq       = pkey_reg == rd_score;
    assign i_inc    = i_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[cnt_reg[ADDR_W-1:0]] <= {s_tuser, s_tdata};
        end
        rd_data_reg <= mem[rd_addr];
    end

    rsa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (twu_reg),
        .den     ({prod_reg, 1'b0}),
        .done    (div_done),
        .quo     (div_quo)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        npos_next    = npos_reg;
        nneg_next    = nneg_reg;
        ovf_next     = ovf_reg;
        degen_next   = degen_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        vld_next     = 1'b0;
        pkey_next    = pkey_reg;
        twu_next     = twu_reg;
        prod_next    = prod_reg;
        rd_addr      = i_reg[ADDR_W-1:0];
        div_start    = 1'b0;
        m_valid_next = m_valid_reg && !m_tready;
        auc_next     = auc_reg;
        odeg_next    = odeg_reg;
        oovf_next    = oovf_reg;

        case (state_reg)
            ST_LOAD: begin
                if (accept) begin
                    if (room) begin
                        cnt_next = cnt_reg + 1'b1;
                        if (s_tuser) begin
                            npos_next = npos_reg + 1'b1;
                        end else begin
                            nneg_next = nneg_reg + 1'b1;
                        end
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        degen_next = (npos_next == '0) || (nneg_next == '0);
                        i_next     = '0;
                        twu_next   = '0;
                        state_next = degen_next ? ST_DONE : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (rd_label) begin
                    pkey_next  = rd_score;
                    j_next     = '0;
                    state_next = ST_SCAN;
                end else begin
                    i_next     = i_inc;
                    state_next = (i_inc == cnt_reg) ? ST_MULT : ST_FETCH;
                end
            end
            ST_SCAN: begin
                // data of entry j-1 arrives while entry j is being read
                if (vld_reg && !rd_label) begin
                    if (gt) begin
                        twu_next = twu_reg + U_W'(2);
                    end else if (eq) begin
                        twu_next = twu_reg + U_W'(1);
                    end
                end
                if (j_reg != cnt_reg) begin
                    rd_addr  = j_reg[ADDR_W-1:0];
                    j_next   = j_reg + 1'b1;
                    vld_next = 1'b1;
                end else begin
                    i_next     = i_inc;
                    state_next = (i_inc == cnt_reg) ? ST_MULT : ST_FETCH;
                end
            end
            ST_MULT: begin
                prod_next  = npos_reg * nneg_reg;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    auc_next     = degen_reg ? '0 : div_quo;
                    odeg_next    = degen_reg;
                    oovf_next    = ovf_reg;
                    cnt_next     = '0;
                    npos_next    = '0;
                    nneg_next    = '0;
                    ovf_next     = 1'b0;
                    state_next   = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            npos_reg    <= '0;
            nneg_reg    <= '0;
            ovf_reg     <= 1'b0;
            vld_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            npos_reg    <= npos_next;
            nneg_reg    <= nneg_next;
            ovf_reg     <= ovf_next;
            vld_reg     <= vld_next;
            m_valid_reg <= m_valid_next;
        end
        degen_reg <= degen_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        pkey_reg  <= pkey_next;
        twu_reg   <= twu_next;
        prod_reg  <= prod_next;
        auc_reg   <= auc_next;
        odeg_reg  <= odeg_next;
        oovf_reg  <= oovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(auc_reg);
    assign m_tuser  = {oovf_reg, odeg_reg};

endmodule

@@ rtl/rsa_div.sv @@
// Restoring divider, one quotient bit per cycle: quo = floor(num * 2^16 / den), num <= den.
module rsa_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rsa_pkg::U_W-1:0]       num,
    input  logic [rsa_pkg::U_W-1:0]       den,
    output logic                          done,
    output logic [rsa_pkg::AUC_W-1:0]     quo
);
    import rsa_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [STEP_W-1:0]   step_reg,  step_next;
    logic [REM_W-1:0]    rem_reg,   rem_next;
    logic [U_W-1:0]      den_reg,   den_next;
    logic [AUC_W-1:0]    quo_reg,   quo_next;
    logic [REM_W-1:0]    den_ext;
    logic [REM_W-1:0]    diff;
    logic                ge;

    assign den_ext = {1'b0, den_reg};
    assign ge      = rem_reg >= den_ext;
    assign diff    = rem_reg - den_ext;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = STEP_W'(DIV_STEPS);
            rem_next  = {1'b0, num};
            den_next  = den;
            quo_next  = '0;
        end else if (busy_reg) begin
            quo_next  = {quo_reg[AUC_W-2:0], ge};
            rem_next  = (ge ? diff : rem_reg) << 1;
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg <= step_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quo_reg  <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

@@ rtl/rsa_checker.sv @@
// Port-level checks for rank_sum_auc, bound to the top level.
module rsa_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic                              s_tlast,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [rsa_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  logic [rsa_pkg::OUT_TUSER_W-1:0]   m_tuser
);
    import rsa_pkg::*;

    // a held result word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // the last word of a set closes the input until the result is formed
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last word");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0)
        else $error("degenerate set with nonzero auc");

    a_auc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata <= OUT_TDATA_W'(1 << (AUC_W - 1)))
        else $error("auc above 1.0");

endmodule

bind rank_sum_auc rsa_checker u_rsa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
